// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the console writer RTL
// Each macro samples on clk and is disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every sampled edge
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Expression must never be true at a sampled edge
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and codes shared by the text console writer top, front and back.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// Operation codes of a request
	localparam logic [1:0] OP_PUT   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	// Character codes with a meaning of their own
	localparam logic [7:0] CH_BACKSPACE = 8'd8;
	localparam logic [7:0] CH_NEWLINE   = 8'd10;
	localparam logic [7:0] CH_RETURN    = 8'd13;
	localparam logic [7:0] CH_SPACE     = 8'd32;

	// Configuration register indexes
	localparam logic [1:0] CFG_BLANK_FG = 2'd0;
	localparam logic [1:0] CFG_BLANK_BG = 2'd1;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic [3:0] fore_colour;
		logic [3:0] back_colour;
		logic [4:0] read_row;
		logic [6:0] read_column;
	} tcw_request_t;

	typedef struct packed {
		logic [15:0] cell_data;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_column;
		logic        scrolled;
	} tcw_response_t;

	// Command class decided by the front
	typedef enum logic [2:0] {
		KIND_CHAR,
		KIND_NEWLINE,
		KIND_RETURN,
		KIND_BACKSPACE,
		KIND_CLEAR,
		KIND_READ,
		KIND_NOP
	} tcw_kind_t;

	typedef struct packed {
		tcw_kind_t   kind;
		logic [15:0] wr_cell;
		logic [4:0]  rd_row;
		logic [6:0]  rd_col;
		logic        rd_ok;
	} tcw_cmd_t;

	// Back engine states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_DRAIN,
		ST_CLEAR
	} tcw_state_t;

endpackage

`default_nettype wire

// File: rtl/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_queue #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = slot_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed entry
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Classify a request into a command for the back engine and range check reads.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_front
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire tcw_request_t request,
	output tcw_cmd_t          cmd
);

	// Decode operation and character class
	always_comb begin
		cmd.kind = KIND_NOP;
		unique case (request.op)
			OP_PUT: begin
				case (request.char_code)
					CH_NEWLINE:   cmd.kind = KIND_NEWLINE;
					CH_RETURN:    cmd.kind = KIND_RETURN;
					CH_BACKSPACE: cmd.kind = KIND_BACKSPACE;
					default:      cmd.kind = KIND_CHAR;
				endcase
			end
			OP_CLEAR: cmd.kind = KIND_CLEAR;
			OP_READ:  cmd.kind = KIND_READ;
			default:  cmd.kind = KIND_NOP;
		endcase

		// Build the cell to write: backspace blanks with the given colours
		cmd.wr_cell[15:12] = request.back_colour;
		cmd.wr_cell[11:8]  = request.fore_colour;
		cmd.wr_cell[7:0]   = (request.char_code == CH_BACKSPACE) ? CH_SPACE
		                                                         : request.char_code;

		// Pass the read position and flag reads that fall off the screen
		cmd.rd_row = request.read_row;
		cmd.rd_col = request.read_column;
		cmd.rd_ok  = (32'(request.read_row) < SCREEN_ROWS) &&
		             (32'(request.read_column) < SCREEN_COLUMNS);
	end

endmodule

`default_nettype wire

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Execute commands against the screen memory and the cursor, one at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_back
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cmd_empty,
	input  wire tcw_cmd_t    cmd,
	output logic             cmd_pop,
	input  wire logic        res_full,
	output logic             res_push,
	output tcw_response_t    res,
	input  wire logic [15:0] blank_cell
);

	localparam int CELL_COUNT  = SCREEN_ROWS * SCREEN_COLUMNS;
	localparam int SHIFT_COUNT = CELL_COUNT - SCREEN_COLUMNS;
	localparam int ADDR_W      = $clog2(CELL_COUNT);
	localparam int ROW_W       = $clog2(SCREEN_ROWS);
	localparam int COL_W       = $clog2(SCREEN_COLUMNS);

	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
	                                                input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(32'(r) * SCREEN_COLUMNS + 32'(c));
	endfunction

	// Screen memory
	logic [15:0]       mem [CELL_COUNT];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [15:0]       mem_wdata;
	logic [ADDR_W-1:0] mem_raddr;
	logic [15:0]       rd_data_s1;

	// Control and cursor
	tcw_state_t        state_q;
	tcw_state_t        state_d;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  row_d;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  col_d;
	logic [ADDR_W-1:0] idx_q;
	logic              rd_ok_q;

	// Scroll copy stage
	logic              wr_vld_s1;
	logic [ADDR_W-1:0] wr_idx_s1;
	logic              wr_blank_s1;

	// Shared decode
	logic              start;
	logic              row_last;
	logic              col_last;
	logic              idx_last;
	logic              needs_scroll;
	logic [ROW_W-1:0]  bs_row;
	logic [COL_W-1:0]  bs_col;

	// Work out cursor moves and the scroll condition
	always_comb begin
		start    = (state_q == ST_IDLE) && !cmd_empty && !res_full;
		row_last = (row_q == ROW_W'(SCREEN_ROWS - 1));
		col_last = (col_q == COL_W'(SCREEN_COLUMNS - 1));
		idx_last = (idx_q == ADDR_W'(CELL_COUNT - 1));
		needs_scroll = row_last &&
		               ((cmd.kind == KIND_NEWLINE) || ((cmd.kind == KIND_CHAR) && col_last));
		bs_row = row_q;
		bs_col = col_q;
		if (col_q != '0) begin
			bs_col = col_q - 1'b1;
		end else if (row_q != '0) begin
			bs_row = row_q - 1'b1;
			bs_col = COL_W'(SCREEN_COLUMNS - 1);
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (needs_scroll) begin
						state_d = ST_SCROLL;
					end else if (cmd.kind == KIND_CLEAR) begin
						state_d = ST_CLEAR;
					end else if (cmd.kind == KIND_READ) begin
						state_d = ST_READ;
					end
				end
			end
			ST_READ:   state_d = ST_IDLE;
			ST_SCROLL: state_d = idx_last ? ST_DRAIN : ST_SCROLL;
			ST_DRAIN:  state_d = ST_IDLE;
			ST_CLEAR:  state_d = idx_last ? ST_IDLE : ST_CLEAR;
			default:   state_d = ST_IDLE;
		endcase
	end

	// Outputs: memory ports, cursor update, command pop and result transfer
	always_comb begin
		cmd_pop       = start;
		res_push      = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = cell_addr(row_q, col_q);
		mem_wdata     = cmd.wr_cell;
		mem_raddr     = ADDR_W'(32'(cmd.rd_row) * SCREEN_COLUMNS + 32'(cmd.rd_col));
		row_d         = row_q;
		col_d         = col_q;
		res.cell_data = '0;
		res.scrolled  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					case (cmd.kind)
						KIND_CHAR: begin
							mem_we = 1'b1;
							if (col_last) begin
								col_d    = '0;
								row_d    = row_last ? row_q : row_q + 1'b1;
								res_push = !row_last;
							end else begin
								col_d    = col_q + 1'b1;
								res_push = 1'b1;
							end
						end
						KIND_NEWLINE: begin
							col_d    = '0;
							row_d    = row_last ? row_q : row_q + 1'b1;
							res_push = !row_last;
						end
						KIND_RETURN: begin
							col_d    = '0;
							res_push = 1'b1;
						end
						KIND_BACKSPACE: begin
							row_d     = bs_row;
							col_d     = bs_col;
							mem_we    = 1'b1;
							mem_waddr = cell_addr(bs_row, bs_col);
							res_push  = 1'b1;
						end
						KIND_CLEAR: begin
							row_d = '0;
							col_d = '0;
						end
						KIND_READ: ;
						default:   res_push = 1'b1;
					endcase
				end
			end
			ST_READ: begin
				res_push      = 1'b1;
				res.cell_data = rd_ok_q ? rd_data_s1 : '0;
			end
			ST_SCROLL: begin
				mem_raddr = idx_q + ADDR_W'(SCREEN_COLUMNS);
			end
			ST_DRAIN: begin
				res_push     = 1'b1;
				res.scrolled = 1'b1;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = blank_cell;
				res_push  = idx_last;
			end
			default: ;
		endcase
		// The scroll copy stage owns the write port whenever it holds an entry
		if (wr_vld_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wr_idx_s1;
			mem_wdata = wr_blank_s1 ? blank_cell : rd_data_s1;
		end
		res.cursor_row    = 5'(row_d);
		res.cursor_column = 7'(col_d);
	end

	// Hold state, cursor and sweep index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			row_q     <= '0;
			col_q     <= '0;
			idx_q     <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_d;
			row_q     <= row_d;
			col_q     <= col_d;
			idx_q     <= (state_q == ST_SCROLL || state_q == ST_CLEAR) ? idx_q + 1'b1 : '0;
			wr_vld_s1 <= (state_q == ST_SCROLL);
		end
	end

	// Capture the copy target and the read range flag
	always_ff @(posedge clk) begin
		wr_idx_s1   <= idx_q;
		wr_blank_s1 <= (idx_q >= ADDR_W'(SHIFT_COUNT));
		if (start) begin
			rd_ok_q <= cmd.rd_ok;
		end
	end

	// Screen memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= mem[mem_raddr];
	end

endmodule

`default_nettype wire

// File: rtl/text_console_writer.sv
// A put, return, backspace or unused op passes the command queue, the back engine in
// ST_IDLE and the result queue; a read adds ST_READ, a scroll the ST_SCROLL copy and
// ST_DRAIN; a clear sweeps all cells in ST_CLEAR, one cell write per cycle. Without a
// sweep or full result queue, one put per cycle, set by the single screen write port.
// Reset clears cursor, queues and engine state and loads the blank colours (7, 0);
// screen memory has no clearing pass and holds garbage until written.
`default_nettype none

`include "assert_macros.svh"

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int SCREEN_COLUMNS = 80,
	parameter int SCREEN_ROWS    = 25
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	output logic               full,
	input  wire tcw_request_t  request,
	output logic               empty,
	input  wire logic          pop,
	output tcw_response_t      response,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [3:0]    cfg_data
);

	localparam int CMD_W = $bits(tcw_cmd_t);
	localparam int RES_W = $bits(tcw_response_t);

	logic [3:0]       blank_fg_q;
	logic [3:0]       blank_bg_q;
	logic [15:0]      blank_cell;
	tcw_cmd_t         front_cmd;
	logic [CMD_W-1:0] cmd_rdata;
	tcw_cmd_t         back_cmd;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;
	tcw_response_t    back_res;
	logic [RES_W-1:0] res_rdata;
	logic             scroll_push;
	logic             scroll_home;
	logic             col_in_range;

	// Take configuration writes at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blank_fg_q <= 4'd7;
			blank_bg_q <= 4'd0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BLANK_FG: blank_fg_q <= cfg_data;
				CFG_BLANK_BG: blank_bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign blank_cell = {blank_bg_q, blank_fg_q, CH_SPACE};

	// Front: classify the request
	tcw_front #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_front (
		.request(request),
		.cmd    (front_cmd)
	);

	// Command queue between front and back
	tcw_queue #(
		.WIDTH(CMD_W),
		.DEPTH(2)
	) u_cmd_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (front_cmd),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_rdata),
		.empty (cmd_empty)
	);

	assign back_cmd = tcw_cmd_t'(cmd_rdata);

	// Back: execute against screen and cursor
	tcw_back #(
		.SCREEN_COLUMNS(SCREEN_COLUMNS),
		.SCREEN_ROWS   (SCREEN_ROWS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (back_cmd),
		.cmd_pop   (cmd_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res       (back_res),
		.blank_cell(blank_cell)
	);

	// Result queue toward the consumer
	tcw_queue #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (back_res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_rdata),
		.empty (empty)
	);

	assign response = tcw_response_t'(res_rdata);

	// Terms for the checks below
	assign scroll_push  = res_push && back_res.scrolled;
	assign scroll_home  = (back_res.cursor_row == 5'(SCREEN_ROWS - 1)) &&
	                      (back_res.cursor_column == '0);
	assign col_in_range = (32'(back_res.cursor_column) < SCREEN_COLUMNS) ||
	                      (SCREEN_COLUMNS > 128);

	// Checks on the engine's own handshakes and results
	`ASSERT_NEVER(a_res_overflow, res_push && res_full, "result pushed into a full queue")
	`ASSERT_ALWAYS(a_pop_room, cmd_pop |-> (!cmd_empty && !res_full), "command taken without room")
	`ASSERT_ALWAYS(a_scroll_pos, scroll_push |-> scroll_home, "scroll left cursor off bottom row")
	`ASSERT_ALWAYS(a_col_range, res_push |-> col_in_range, "cursor column beyond the screen")

endmodule

`default_nettype wire

// File: tb/sv/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Drives put, clear, read and unused requests into the console writer.
// A screen scoreboard keeps its own copy of the cells, the cursor and the
// blank colours. It works out the response of every accepted request and
// checks the responses field by field, in order. Both sides idle at random,
// and one long hold-off on the response side fills the block up.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_text_console_writer;
	import tcw_pkg::*;

	localparam int CONSOLE_COLUMNS = 80;
	localparam int CONSOLE_ROWS    = 25;
	localparam int CONSOLE_CELLS   = CONSOLE_COLUMNS * CONSOLE_ROWS;

	// op 3 has no meaning: the block only reports the cursor
	localparam logic [1:0] OP_UNUSED = 2'd3;

	localparam int ITEMS_PER_PHASE = 390;
	localparam int PHASE_COUNT     = 5;
	localparam int STALL_LIMIT     = 20000;
	localparam int SETTLE_CYCLES   = CONSOLE_CELLS + 16;
	localparam int DRAIN_CYCLES    = 16;
	localparam int IDLE_PERCENT    = 8;
	localparam int PRESSURE_AT     = 1000;
	localparam int PRESSURE_CYCLES = 400;
	localparam int REPORT_CAP      = 40;

	class screen_scoreboard;
		logic [15:0]   cells [CONSOLE_CELLS];
		int            cur_row;
		int            cur_col;
		logic [3:0]    blank_fg;
		logic [3:0]    blank_bg;
		tcw_response_t pending_responses[$];
		int unsigned   mismatches;
		int unsigned   checked;

		function new();
			foreach (cells[i])
				cells[i] = '0;
			cur_row = 0;
			cur_col = 0;
			blank_fg = 4'd7;
			blank_bg = 4'd0;
			mismatches = 0;
			checked = 0;
		endfunction

		function int pending();
			return pending_responses.size();
		endfunction

		function void note_config(logic [1:0] index, logic [3:0] value);
			case (index)
				CFG_BLANK_FG: blank_fg = value;
				CFG_BLANK_BG: blank_bg = value;
				default: ;
			endcase
		endfunction

		// Step down one row; scroll up and blank the bottom row past the end
		function bit advance_row();
			cur_row++;
			if (cur_row < CONSOLE_ROWS)
				return 1'b0;
			for (int i = 0; i < CONSOLE_CELLS - CONSOLE_COLUMNS; i++)
				cells[i] = cells[i + CONSOLE_COLUMNS];
			for (int i = CONSOLE_CELLS - CONSOLE_COLUMNS; i < CONSOLE_CELLS; i++)
				cells[i] = {blank_bg, blank_fg, CH_SPACE};
			cur_row = CONSOLE_ROWS - 1;
			return 1'b1;
		endfunction

		function bit put_char(tcw_request_t req);
			case (req.char_code)
				CH_NEWLINE: begin
					cur_col = 0;
					return advance_row();
				end
				CH_RETURN: begin
					cur_col = 0;
					return 1'b0;
				end
				CH_BACKSPACE: begin
					// step back across the line edge, stay put at home
					if (cur_col > 0) begin
						cur_col--;
					end else if (cur_row > 0) begin
						cur_row--;
						cur_col = CONSOLE_COLUMNS - 1;
					end
					cells[cur_row * CONSOLE_COLUMNS + cur_col] =
						{req.back_colour, req.fore_colour, CH_SPACE};
					return 1'b0;
				end
				default: begin
					cells[cur_row * CONSOLE_COLUMNS + cur_col] =
						{req.back_colour, req.fore_colour, req.char_code};
					cur_col++;
					if (cur_col >= CONSOLE_COLUMNS) begin
						cur_col = 0;
						return advance_row();
					end
					return 1'b0;
				end
			endcase
		endfunction

		// Apply one accepted request and queue the response it should give
		function void note_request(tcw_request_t req);
			tcw_response_t want;
			want = '0;
			case (req.op)
				OP_PUT: want.scrolled = put_char(req);
				OP_CLEAR: begin
					foreach (cells[i])
						cells[i] = {blank_bg, blank_fg, CH_SPACE};
					cur_row = 0;
					cur_col = 0;
				end
				OP_READ: begin
					if (req.read_row < CONSOLE_ROWS && req.read_column < CONSOLE_COLUMNS)
						want.cell_data = cells[req.read_row * CONSOLE_COLUMNS + req.read_column];
				end
				default: ;
			endcase
			want.cursor_row = 5'(cur_row);
			want.cursor_column = 7'(cur_col);
			pending_responses.push_back(want);
		endfunction

		task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
			if (mismatches < REPORT_CAP)
				$display("[%0t] response %0d: %s got 0x%0h expected 0x%0h",
					$time, checked, what, got, want);
			mismatches++;
		endtask

		task check_response(tcw_response_t got);
			tcw_response_t want;
			checked++;
			if (pending_responses.size() == 0) begin
				report_mismatch("response with nothing pending", 32'(got), 32'd0);
				return;
			end
			want = pending_responses.pop_front();
			if (got.cell_data !== want.cell_data)
				report_mismatch("cell_data", 32'(got.cell_data), 32'(want.cell_data));
			if (got.cursor_row !== want.cursor_row)
				report_mismatch("cursor_row", 32'(got.cursor_row), 32'(want.cursor_row));
			if (got.cursor_column !== want.cursor_column)
				report_mismatch("cursor_column", 32'(got.cursor_column),
					32'(want.cursor_column));
			if (got.scrolled !== want.scrolled)
				report_mismatch("scrolled", 32'(got.scrolled), 32'(want.scrolled));
		endtask
	endclass

	logic          clk;
	logic          arst_n;
	logic          push;
	logic          full;
	tcw_request_t  request;
	logic          empty;
	logic          pop;
	tcw_response_t response;
	logic          cfg_valid;
	logic          cfg_ready;
	logic [1:0]    cfg_index;
	logic [3:0]    cfg_data;

	screen_scoreboard board;
	int unsigned      requests_sent;
	int unsigned      results_taken;
	int unsigned      stall_cycles;

	text_console_writer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.request   (request),
		.empty     (empty),
		.pop       (pop),
		.response  (response),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic tcw_request_t make_request(logic [1:0] op, logic [7:0] ch,
			logic [3:0] fg, logic [3:0] bg, logic [4:0] rr, logic [6:0] rc);
		tcw_request_t req;
		req.op = op;
		req.char_code = ch;
		req.fore_colour = fg;
		req.back_colour = bg;
		req.read_row = rr;
		req.read_column = rc;
		return req;
	endfunction

	// Mostly text with line breaks and backspaces, some reads, rare clears
	function automatic tcw_request_t random_request();
		tcw_request_t req;
		int unsigned  pick;
		int unsigned  kind;
		req = tcw_request_t'(30'($urandom));
		pick = $urandom_range(999);
		if (pick < 3) begin
			req.op = OP_CLEAR;
		end else if (pick < 13) begin
			req.op = OP_UNUSED;
		end else if (pick < 150) begin
			req.op = OP_READ;
			if ($urandom_range(9) != 0) begin
				req.read_row = 5'($urandom_range(CONSOLE_ROWS - 1));
				req.read_column = 7'($urandom_range(CONSOLE_COLUMNS - 1));
			end
		end else begin
			req.op = OP_PUT;
			kind = $urandom_range(99);
			if (kind < 10)
				req.char_code = CH_NEWLINE;
			else if (kind < 14)
				req.char_code = CH_RETURN;
			else if (kind < 24)
				req.char_code = CH_BACKSPACE;
		end
		return req;
	endfunction

	// Offer one request from a falling edge and hold it until it transfers
	task automatic send_request(tcw_request_t req);
		bit calm;
		calm = (requests_sent >= 300 && requests_sent < 700);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		request <= req;
		do
			@(posedge clk);
		while (full);
		board.note_request(req);
		requests_sent++;
		@(negedge clk);
	endtask

	// Let the block drain and finish any background pass before a write
	task automatic wait_until_idle();
		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic set_blank_colours(logic [3:0] fg, logic [3:0] bg);
		logic [1:0] index [2];
		logic [3:0] value [2];
		index[0] = CFG_BLANK_FG;
		index[1] = CFG_BLANK_BG;
		value[0] = fg;
		value[1] = bg;
		for (int i = 0; i < 2; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= index[i];
			cfg_data <= value[i];
			do
				@(posedge clk);
			while (!cfg_ready);
			board.note_config(index[i], value[i]);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
	endtask

	// Pop responses; one long hold-off lets the block fill up
	initial begin : drain_responses
		int unsigned hold_left;
		bit          held;
		held = 1'b0;
		hold_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_taken >= PRESSURE_AT) begin
				held = 1'b1;
				hold_left = PRESSURE_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (results_taken >= 1200 && results_taken < 1500) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= IDLE_PERCENT);
			end
			@(posedge clk);
			if (pop && !empty) begin
				results_taken++;
				board.check_response(response);
			end
		end
	end

	// Stop the run when nothing has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("text_console_writer test failed");
				$finish;
			end
		end
	end

	initial begin : run_stimulus
		tcw_request_t directed_q[$];
		logic [3:0]   phase_fg [PHASE_COUNT];
		logic [3:0]   phase_bg [PHASE_COUNT];

		arst_n = 1'b0;
		push = 1'b0;
		request = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_BLANK_FG;
		cfg_data = '0;
		requests_sent = 0;
		results_taken = 0;
		stall_cycles = 0;
		board = new();

		phase_fg = '{4'd0, 4'd15, 4'd0, 4'd15, 4'($urandom)};
		phase_bg = '{4'd0, 4'd15, 4'd15, 4'd0, 4'($urandom)};

		// Clear first: no cell may be read before it is written
		directed_q.push_back(make_request(OP_CLEAR, 8'd0, 4'd0, 4'd0, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_PUT, 8'h41, 4'd15, 4'd15, 5'd0, 7'd0));
		// high character codes stay out of the colour byte
		directed_q.push_back(make_request(OP_PUT, 8'hFF, 4'd0, 4'd0, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_PUT, 8'h00, 4'd15, 4'd0, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd1));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd24, 7'd79));
		// reads beyond the screen give zero
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd31, 7'd127));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd25, 7'd0));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd80));
		directed_q.push_back(make_request(OP_PUT, CH_BACKSPACE, 4'd3, 4'd12, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd2));
		directed_q.push_back(make_request(OP_PUT, CH_RETURN, 4'd0, 4'd0, 5'd0, 7'd0));
		// backspace at home stays and blanks the home cell
		directed_q.push_back(make_request(OP_PUT, CH_BACKSPACE, 4'd10, 4'd5, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_PUT, CH_NEWLINE, 4'd0, 4'd0, 5'd0, 7'd0));
		// backspace at row start goes to the end of the row above
		directed_q.push_back(make_request(OP_PUT, CH_BACKSPACE, 4'd1, 4'd14, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd79));
		directed_q.push_back(make_request(OP_UNUSED, 8'hFF, 4'd15, 4'd15, 5'd31, 7'd127));
		// a write in the last column wraps to the next line
		directed_q.push_back(make_request(OP_PUT, 8'h80, 4'd9, 4'd6, 5'd0, 7'd0));
		directed_q.push_back(make_request(OP_READ, 8'd0, 4'd0, 4'd0, 5'd0, 7'd79));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed requests under the reset blank colours
		foreach (directed_q[i])
			send_request(directed_q[i]);

		// Random phases, each under its own blank colours
		for (int p = 0; p < PHASE_COUNT; p++) begin
			wait_until_idle();
			set_blank_colours(phase_fg[p], phase_bg[p]);
			repeat (ITEMS_PER_PHASE) send_request(random_request());
		end

		push <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.mismatches == 0 && board.pending() == 0) begin
			$display("text_console_writer test passed");
		end else begin
			$display("text_console_writer test failed");
		end
		$finish;
	end

endmodule

// File: text_console_writer.f
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_queue.sv
rtl/tcw_front.sv
rtl/tcw_back.sv
rtl/text_console_writer.sv
tb/sv/tb_text_console_writer.sv
